// ----- design/ima_adpcm_stereo_encoder_assert.svh -----
// Assertion macros shared by the stereo ADPCM encoder RTL.
`ifndef IMA_ADPCM_STEREO_ENCODER_ASSERT_SVH
`define IMA_ADPCM_STEREO_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define IMAENC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define IMAENC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) (expr)) else $error(msg);
`else
`define IMAENC_ASSERT(lbl, expr, msg)
`define IMAENC_ASSERT_ALWAYS(lbl, expr, msg)
`endif

`endif

// ----- design/imaenc_pkg.sv -----
// Types, constants and tables for the stereo ADPCM encoder.
package imaenc_pkg;

    localparam int STEP_COUNT = 89;

    localparam logic [6:0] INDEX_MAX = 7'd88;
    localparam logic signed [15:0] PRED_MAX = 16'sh7FFF;
    localparam logic signed [15:0] PRED_MIN = -16'sh8000;

    typedef logic [14:0] t_step;

    typedef struct packed {
        logic signed [15:0] pred;
        logic [6:0]         idx;
    } t_chan_state;

    localparam t_step STEP_TABLE [0:STEP_COUNT-1] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [7:0] INDEX_MOVES [0:7] = '{
        -8'sd1, -8'sd1, -8'sd1, -8'sd1, 8'sd2, 8'sd4, 8'sd6, 8'sd8
    };

endpackage

// ----- design/imaenc_channel.sv -----
// One channel of IMA-ADPCM encoding: code, predictor update and index update.
module imaenc_channel import imaenc_pkg::*; (
    input  logic signed [15:0] i_sample,
    input  t_chan_state        i_state,
    output logic [3:0]         o_code,
    output t_chan_state        o_state
);

    logic [6:0]         si;
    t_step              step;
    logic [15:0]        step_full;
    logic [15:0]        step_half;
    logic [15:0]        step_quarter;
    logic signed [16:0] diff;
    logic signed [16:0] diff_neg;
    logic [15:0]        mag;
    logic [15:0]        rem1;
    logic [15:0]        rem2;
    logic [15:0]        delta;
    logic signed [17:0] pred_sum;
    logic signed [7:0]  idx_sum;

    always_comb begin
        si           = (i_state.idx > INDEX_MAX) ? INDEX_MAX : i_state.idx;
        step         = STEP_TABLE[si];
        step_full    = {1'b0, step};
        step_half    = {2'b00, step[14:1]};
        step_quarter = {3'b000, step[14:2]};

        diff     = $signed({i_sample[15], i_sample}) - $signed({i_state.pred[15], i_state.pred});
        diff_neg = -diff;
        o_code[3] = diff[16];
        mag       = diff[16] ? diff_neg[15:0] : diff[15:0];

        o_code[2] = (mag >= step_full);
        rem1      = o_code[2] ? (mag - step_full) : mag;
        o_code[1] = (rem1 >= step_half);
        rem2      = o_code[1] ? (rem1 - step_half) : rem1;
        o_code[0] = (rem2 >= step_quarter);

        delta = {4'b0000, step[14:3]}
              + (o_code[2] ? step_full : 16'd0)
              + (o_code[1] ? step_half : 16'd0)
              + (o_code[0] ? step_quarter : 16'd0);

        if (o_code[3]) begin
            pred_sum = $signed({{2{i_state.pred[15]}}, i_state.pred}) - $signed({2'b00, delta});
        end else begin
            pred_sum = $signed({{2{i_state.pred[15]}}, i_state.pred}) + $signed({2'b00, delta});
        end

        priority if (pred_sum > $signed({{2{PRED_MAX[15]}}, PRED_MAX})) begin
            o_state.pred = PRED_MAX;
        end else if (pred_sum < $signed({{2{PRED_MIN[15]}}, PRED_MIN})) begin
            o_state.pred = PRED_MIN;
        end else begin
            o_state.pred = pred_sum[15:0];
        end

        idx_sum = $signed({1'b0, si}) + INDEX_MOVES[o_code[2:0]];
        priority if (idx_sum < 8'sd0) begin
            o_state.idx = 7'd0;
        end else if (idx_sum > $signed({1'b0, INDEX_MAX})) begin
            o_state.idx = INDEX_MAX;
        end else begin
            o_state.idx = idx_sum[6:0];
        end
    end

endmodule

// ----- design/ima_adpcm_stereo_encoder.sv -----
// Stereo IMA-ADPCM encoder: one left/right sample pair in, one packed code byte out
// per transfer. A pair is taken every clock cycle while the output keeps up. The pair
// sits in the input register while the encode logic works on it, and it moves into
// the result register, which drives the output, once that register is empty or its
// result is being taken. The rate is set by the channel state loop: predictor and
// step index are rewritten at the same edge that moves a pair into the result
// register, so the next pair sees them at once. Restart clears both channel states
// before the pair that carries it is encoded.
`include "ima_adpcm_stereo_encoder_assert.svh"

module ima_adpcm_stereo_encoder import imaenc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_left_sample,
    input  logic signed [15:0] i_right_sample,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_packed_codes,
    output logic signed [15:0] o_left_pred_before,
    output logic [6:0]         o_left_index_before,
    output logic signed [15:0] o_right_pred_before,
    output logic [6:0]         o_right_index_before
);

    logic               r_in_valid;
    logic signed [15:0] r_left_sample;
    logic signed [15:0] r_right_sample;
    logic               r_restart;
    logic               r_out_valid;
    logic [7:0]         r_packed_codes;
    t_chan_state        r_left_before;
    t_chan_state        r_right_before;
    t_chan_state        r_left_state;
    t_chan_state        r_right_state;

    t_chan_state        cur_left;
    t_chan_state        cur_right;
    t_chan_state        n_left_state;
    t_chan_state        n_right_state;
    logic [3:0]         left_code;
    logic [3:0]         right_code;
    logic               advance;
    logic               accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    assign cur_left  = r_restart ? '0 : r_left_state;
    assign cur_right = r_restart ? '0 : r_right_state;

    imaenc_channel u_left (
        .i_sample (r_left_sample),
        .i_state  (cur_left),
        .o_code   (left_code),
        .o_state  (n_left_state)
    );

    imaenc_channel u_right (
        .i_sample (r_right_sample),
        .i_state  (cur_right),
        .o_code   (right_code),
        .o_state  (n_right_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_left_state  <= '0;
            r_right_state <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_left_state  <= n_left_state;
                r_right_state <= n_right_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left_sample  <= i_left_sample;
            r_right_sample <= i_right_sample;
            r_restart      <= i_restart;
        end
        if (advance) begin
            r_packed_codes <= {right_code, left_code};
            r_left_before  <= cur_left;
            r_right_before <= cur_right;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_packed_codes       = r_packed_codes;
    assign o_left_pred_before   = r_left_before.pred;
    assign o_left_index_before  = r_left_before.idx;
    assign o_right_pred_before  = r_right_before.pred;
    assign o_right_index_before = r_right_before.idx;

    `IMAENC_ASSERT(a_index_range, (r_left_state.idx <= INDEX_MAX) && (r_right_state.idx <= INDEX_MAX), "step index left 0..88")
    `IMAENC_ASSERT(a_restart_before, (advance && r_restart) |=> ((r_left_before == '0) && (r_right_before == '0)), "restart pair did not report cleared state")
    `IMAENC_ASSERT(a_result_hold, (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_packed_codes)), "stalled result dropped or changed")
    `IMAENC_ASSERT(a_state_hold, !advance |=> ($stable(r_left_state) && $stable(r_right_state)), "channel state moved without a pair")
    `IMAENC_ASSERT_ALWAYS(a_stall_needs_item, o_in_stall |-> r_in_valid, "input stalled with empty input register")

endmodule
